@@ rtl/oacs_pkg.sv @@
// Package for the open-addressed coordinate hash set.
// Transfer payload types, status codes and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package oacs_pkg;

  // width of one coordinate and of one table slot word
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SLOT_W  = 2 * COORD_W;

  // xorshift shift amounts
  localparam int unsigned MIX_SH_A = 13;
  localparam int unsigned MIX_SH_B = 17;
  localparam int unsigned MIX_SH_C = 5;

  // operation codes
  typedef enum logic {
    OP_FIND   = 1'b0,
    OP_INSERT = 1'b1
  } opcode_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RESERVED = 2'd2
  } status_t;

  // input transfer
  typedef struct packed {
    opcode_t                    opcode;
    logic signed [COORD_W-1:0]  key_x;
    logic signed [COORD_W-1:0]  key_y;
  } in_item_t;

  // result transfer
  typedef struct packed {
    logic    found;
    status_t status;
  } out_item_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESULT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/open_address_coordinate_set_top.sv @@
// Open-addressed hash set of (x,y) coordinate keys with double hashing.
// An item passes through S_IDLE, S_HASH, S_PROBE once per slot probed (one slot-table
// read per cycle), then S_RESULT; a reserved key goes from S_HASH straight to S_RESULT.
// Throughput: one item at a time; next item is taken once the result is queued.
// Reset: after rst_n the slot table is cleared for 2^TABLE_LOG2 cycles, in_stall high.
// Depends on oacs_pkg, oacs_hash, oacs_ram.
`timescale 1ns / 1ps
`default_nettype none

module open_address_coordinate_set_top #(
  parameter int unsigned TABLE_LOG2 = 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire oacs_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output oacs_pkg::out_item_t       out_data
);

  localparam int unsigned DEPTH = 1 << TABLE_LOG2;
  localparam int unsigned SW    = oacs_pkg::SLOT_W;
  localparam int unsigned CW    = oacs_pkg::COORD_W;

  oacs_pkg::state_t    state_r, state_nxt;
  logic [TABLE_LOG2-1:0] clr_r, clr_nxt;
  logic [TABLE_LOG2-1:0] idx_r, idx_nxt;
  logic [TABLE_LOG2-1:0] start_r, start_nxt;
  logic [TABLE_LOG2-1:0] step_r, step_nxt;
  oacs_pkg::opcode_t   op_r, op_nxt;
  logic [SW-1:0]       key_r, key_nxt;
  logic [SW-1:0]       stored_r, stored_nxt;
  logic                res_found_r, res_found_nxt;
  oacs_pkg::status_t   res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  oacs_pkg::out_item_t out_data_r, out_data_nxt;

  logic [TABLE_LOG2-1:0] hash_start;
  logic [TABLE_LOG2-1:0] hash_step;
  logic [TABLE_LOG2-1:0] idx_adv;
  logic                  ram_we;
  logic [TABLE_LOG2-1:0] ram_waddr;
  logic [SW-1:0]         ram_wdata;
  logic [TABLE_LOG2-1:0] ram_raddr;
  logic [SW-1:0]         ram_rdata;
  logic                  in_fire;
  logic                  out_free;
  logic [CW-1:0]         sx, sy;

  // key hashing
  oacs_hash #(
    .TABLE_LOG2 (TABLE_LOG2)
  ) u_hash (
    .key_word (key_r),
    .start    (hash_start),
    .step     (hash_step)
  );

  // slot table
  oacs_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != oacs_pkg::S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idx_adv   = idx_r + step_r;

  // slot word of an incoming key: each half offset by one
  assign sx = in_data.key_x + {{(CW-1){1'b0}}, 1'b1};
  assign sy = in_data.key_y + {{(CW-1){1'b0}}, 1'b1};

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= oacs_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    step_r       <= step_nxt;
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    stored_r     <= stored_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  // sequencer: next state, probe control and table access
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    step_nxt       = step_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    stored_nxt     = stored_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = stored_r;
    ram_raddr      = idx_adv;

    case (state_r)
      // clearing pass over every slot
      oacs_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + {{(TABLE_LOG2-1){1'b0}}, 1'b1};
        if (clr_r == {TABLE_LOG2{1'b1}}) begin
          state_nxt = oacs_pkg::S_IDLE;
        end
      end

      // take a new item
      oacs_pkg::S_IDLE: begin
        if (in_fire) begin
          op_nxt     = in_data.opcode;
          key_nxt    = {in_data.key_y, in_data.key_x};
          stored_nxt = {sy, sx};
          state_nxt  = oacs_pkg::S_HASH;
        end
      end

      // hash the key and issue the first slot read
      oacs_pkg::S_HASH: begin
        idx_nxt   = hash_start;
        start_nxt = hash_start;
        step_nxt  = hash_step;
        ram_raddr = hash_start;
        if (stored_r == '0) begin
          res_found_nxt  = 1'b0;
          res_status_nxt = (op_r == oacs_pkg::OP_INSERT) ? oacs_pkg::ST_RESERVED
                                                         : oacs_pkg::ST_OK;
          state_nxt      = oacs_pkg::S_RESULT;
        end else begin
          state_nxt = oacs_pkg::S_PROBE;
        end
      end

      // check one slot per cycle, next slot read already issued
      oacs_pkg::S_PROBE: begin
        res_found_nxt  = 1'b0;
        res_status_nxt = oacs_pkg::ST_OK;
        if (ram_rdata == '0) begin
          ram_we    = (op_r == oacs_pkg::OP_INSERT);
          state_nxt = oacs_pkg::S_RESULT;
        end else if (op_r == oacs_pkg::OP_FIND && ram_rdata == stored_r) begin
          res_found_nxt = 1'b1;
          state_nxt     = oacs_pkg::S_RESULT;
        end else if (idx_adv == start_r) begin
          res_status_nxt = (op_r == oacs_pkg::OP_INSERT) ? oacs_pkg::ST_FULL
                                                         : oacs_pkg::ST_OK;
          state_nxt      = oacs_pkg::S_RESULT;
        end else begin
          idx_nxt = idx_adv;
        end
      end

      // hand the result to the output register
      oacs_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.found  = res_found_r;
          out_data_nxt.status = res_status_r;
          state_nxt           = oacs_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = oacs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/oacs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Used for the slot table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module oacs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/oacs_hash.sv @@
// Xorshift mixer for the coordinate key word: yields start slot and odd probe step.
// Depends on oacs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oacs_hash #(
  parameter int unsigned TABLE_LOG2 = 11
) (
  input  wire logic [oacs_pkg::SLOT_W-1:0] key_word,
  output logic      [TABLE_LOG2-1:0]       start,
  output logic      [TABLE_LOG2-1:0]       step
);

  logic [oacs_pkg::SLOT_W-1:0] mix_a;
  logic [oacs_pkg::SLOT_W-1:0] mix_b;
  logic [oacs_pkg::SLOT_W-1:0] mix_c;

  // three xorshift rounds
  always_comb begin
    mix_a = key_word ^ (key_word << oacs_pkg::MIX_SH_A);
    mix_b = mix_a ^ (mix_a >> oacs_pkg::MIX_SH_B);
    mix_c = mix_b ^ (mix_b << oacs_pkg::MIX_SH_C);
  end

  // low bits pick the start slot, next bits give an odd step
  assign start = mix_c[TABLE_LOG2-1:0];
  assign step  = mix_c[TABLE_LOG2 +: TABLE_LOG2] | {{(TABLE_LOG2-1){1'b0}}, 1'b1};

endmodule

`default_nettype wire
